/* rtl/bfa_pkg.sv */
// ----------------------------------------------------------------------------
// bfa_pkg - shared definitions for the bitmap first-free allocator
// Operation and status codes, controller states and the flag update bundle.
// ----------------------------------------------------------------------------
package bfa_pkg;

  localparam int MAX_BITS_DEF  = 4096;
  localparam int WORD_BITS_DEF = 32;

  localparam int OP_W     = 3;
  localparam int IDX_W    = 12;
  localparam int CFG_W    = 13;
  localparam int STATUS_W = 2;

  localparam logic [CFG_W-1:0] CFG_RESET = 13'd4096;

  // words per group in the first level of the summary search
  localparam int SCAN_GROUP = 16;

  typedef enum logic [OP_W-1:0] {
    OP_TEST      = 3'd0,
    OP_SET       = 3'd1,
    OP_CLEAR     = 3'd2,
    OP_CLAIM     = 3'd3,
    OP_RELEASE   = 3'd4,
    OP_CLEAR_ALL = 3'd5,
    OP_SET_ALL   = 3'd6,
    OP_NOP       = 3'd7
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_NONE  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_RD,
    S_MOD,
    S_RESP
  } state_t;

  // one update of the flag store, seen by the memory and the summaries
  typedef struct packed {
    logic wr;
    logic bulk;
    logic bulk_val;
    logic word_full;
    logic word_empty;
  } flag_upd_t;

endpackage

/* rtl/bfa_if.sv */
// ----------------------------------------------------------------------------
// bfa_if - request and result channels
// Valid/ready channels; a word moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface bfa_in_if;
  logic                        valid;
  logic                        ready;
  logic [bfa_pkg::OP_W-1:0]    operation;
  logic [bfa_pkg::IDX_W-1:0]   bit_index;

  modport source (output valid, output operation, output bit_index, input ready);
  modport sink   (input valid, input operation, input bit_index, output ready);
endinterface

interface bfa_out_if;
  logic                        valid;
  logic                        ready;
  bfa_pkg::status_t            status;
  logic                        previous_value;
  logic [bfa_pkg::IDX_W-1:0]   found_index;

  modport source (output valid, output status, output previous_value, output found_index,
                  input ready);
  modport sink   (input valid, input status, input previous_value, input found_index,
                  output ready);
endinterface

/* rtl/bitmap_first_free_allocator.sv */
// ----------------------------------------------------------------------------
// bitmap_first_free_allocator - bitmap allocator with lowest-free search
// Flag words in a single-port RAM, read-modify-write per request, with
// per-word summaries for the claim and release searches.
// ----------------------------------------------------------------------------
// One request is handled at a time and gives one result word. Test, set and
// clear pass through accept, RAM read, modify and write back, and result;
// claim and release put a summary search step first, and go straight to the
// result when the summaries show nothing to find. Out-of-range requests,
// clear all, set all and the unused code go from accept straight to the
// result. A result waiting in the output register delays only the final
// step. Reset and the bulk operations need no clearing pass: per-word valid
// bits stand in for one, so no sweep follows reset.
// ----------------------------------------------------------------------------
module bitmap_first_free_allocator #(
  parameter int MAX_BITS  = bfa_pkg::MAX_BITS_DEF,
  parameter int WORD_BITS = bfa_pkg::WORD_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [bfa_pkg::CFG_W-1:0]  cfg_wdata,
  bfa_in_if.sink                     in_if,
  bfa_out_if.source                  out_if
);

  localparam int IDX_W      = bfa_pkg::IDX_W;
  localparam int CFG_W      = bfa_pkg::CFG_W;
  localparam int WORD_COUNT = (MAX_BITS + WORD_BITS - 1) / WORD_BITS;
  localparam int WA_W       = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
  localparam int POS_W      = $clog2(WORD_BITS);
  localparam int ACT_W      = ($clog2(MAX_BITS + 1) > CFG_W) ? $clog2(MAX_BITS + 1) : CFG_W;
  localparam int BASE_W     = $clog2(WORD_COUNT * WORD_BITS + 1);
  localparam int CW         = (BASE_W > ACT_W) ? BASE_W : ACT_W;
  // index / WORD_BITS by reciprocal, exact for every IDX_W-bit index
  localparam int SH         = IDX_W + POS_W;
  localparam int RECIP      = ((1 << SH) + WORD_BITS - 1) / WORD_BITS;
  localparam int RECIP_W    = $clog2(RECIP + 1);
  localparam int PROD_W     = IDX_W + RECIP_W;

  bfa_pkg::state_t    state_r, state_nxt;
  bfa_pkg::op_t       in_op, op_r;
  bfa_pkg::status_t   st_r;
  bfa_pkg::status_t   out_status_r;
  bfa_pkg::flag_upd_t upd;

  logic [CFG_W-1:0]     cfg_r;
  logic [ACT_W-1:0]     active_n;
  logic                 in_ready, in_fire, in_range, in_single;
  logic [PROD_W-1:0]    prod;
  logic [IDX_W-1:0]     quot;
  logic [POS_W-1:0]     pos_c;
  logic [WA_W-1:0]      addr_r;
  logic [POS_W-1:0]     pos_r;
  logic                 prev_r;
  logic [IDX_W-1:0]     found_r;
  logic                 scan_start, scan_hit, scan_op;
  logic [WA_W-1:0]      scan_word;
  logic [WORD_BITS-1:0] rd_data, wr_data, cand_bits;
  logic [BASE_W-1:0]    base_c;
  logic [CW-1:0]        lim_c;
  logic [POS_W-1:0]     fpos;
  logic                 fany;
  logic [IDX_W-1:0]     found_c;
  logic                 res_load;
  logic                 out_valid_r, out_prev_r;
  logic [IDX_W-1:0]     out_found_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= bfa_pkg::CFG_RESET;
    end else if (cfg_we) begin
      cfg_r <= cfg_wdata;
    end
  end

  assign active_n = (ACT_W'(cfg_r) > ACT_W'(MAX_BITS)) ? ACT_W'(MAX_BITS) : ACT_W'(cfg_r);

  assign in_op     = bfa_pkg::op_t'(in_if.operation);
  assign in_fire   = in_if.valid && in_ready;
  assign in_range  = ACT_W'(in_if.bit_index) < active_n;
  assign in_single = (in_op == bfa_pkg::OP_TEST) || (in_op == bfa_pkg::OP_SET) ||
                     (in_op == bfa_pkg::OP_CLEAR);
  assign in_if.ready = in_ready;

  assign prod  = PROD_W'(in_if.bit_index) * PROD_W'(RECIP);
  assign quot  = IDX_W'(prod >> SH);
  assign pos_c = POS_W'(in_if.bit_index - IDX_W'(quot * WORD_BITS));

  assign scan_op = (op_r == bfa_pkg::OP_CLAIM) || (op_r == bfa_pkg::OP_RELEASE);

  // controller
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bfa_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    in_ready   = 1'b0;
    scan_start = 1'b0;
    res_load   = 1'b0;
    unique case (state_r)
      bfa_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_if.valid) begin
          unique case (in_op) inside
            bfa_pkg::OP_TEST, bfa_pkg::OP_SET, bfa_pkg::OP_CLEAR: begin
              state_nxt = in_range ? bfa_pkg::S_RD : bfa_pkg::S_RESP;
            end
            bfa_pkg::OP_CLAIM, bfa_pkg::OP_RELEASE: begin
              state_nxt  = bfa_pkg::S_SCAN;
              scan_start = 1'b1;
            end
            default: begin
              state_nxt = bfa_pkg::S_RESP;
            end
          endcase
        end
      end
      bfa_pkg::S_SCAN: begin
        state_nxt = scan_hit ? bfa_pkg::S_RD : bfa_pkg::S_RESP;
      end
      bfa_pkg::S_RD: begin
        state_nxt = bfa_pkg::S_MOD;
      end
      bfa_pkg::S_MOD: begin
        state_nxt = bfa_pkg::S_RESP;
      end
      bfa_pkg::S_RESP: begin
        if (!out_valid_r || out_if.ready) begin
          res_load  = 1'b1;
          state_nxt = bfa_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = bfa_pkg::S_IDLE;
      end
    endcase
  end

  // modify step: word base, active-bit limit and first wanted bit
  assign base_c = BASE_W'(addr_r) * BASE_W'(WORD_BITS);
  assign lim_c  = CW'(active_n) - CW'(base_c);

  always_comb begin
    for (int p = 0; p < WORD_BITS; p++) begin
      cand_bits[p] = (CW'(p) < lim_c) &&
                     ((op_r == bfa_pkg::OP_CLAIM) ? !rd_data[p] : rd_data[p]);
    end
    fany = |cand_bits;
    fpos = '0;
    for (int p = WORD_BITS - 1; p >= 0; p--) begin
      if (cand_bits[p]) begin
        fpos = POS_W'(p);
      end
    end
  end

  assign found_c = IDX_W'(base_c + BASE_W'(fpos));

  always_comb begin
    wr_data = rd_data;
    if (scan_op) begin
      wr_data[fpos] = (op_r == bfa_pkg::OP_CLAIM);
    end else begin
      wr_data[pos_r] = (op_r == bfa_pkg::OP_SET);
    end
  end

  assign upd.wr         = (state_r == bfa_pkg::S_MOD) &&
                          (scan_op ? fany : ((op_r == bfa_pkg::OP_SET) ||
                                             (op_r == bfa_pkg::OP_CLEAR)));
  assign upd.bulk       = in_fire && ((in_op == bfa_pkg::OP_CLEAR_ALL) ||
                                      (in_op == bfa_pkg::OP_SET_ALL));
  assign upd.bulk_val   = (in_op == bfa_pkg::OP_SET_ALL);
  assign upd.word_full  = &wr_data;
  assign upd.word_empty = ~|wr_data;

  // request datapath
  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r    <= in_op;
      addr_r  <= WA_W'(quot);
      pos_r   <= pos_c;
      st_r    <= (in_single && !in_range) ? bfa_pkg::ST_RANGE : bfa_pkg::ST_OK;
      prev_r  <= 1'b0;
      found_r <= '0;
    end
    if (state_r == bfa_pkg::S_SCAN) begin
      addr_r <= scan_word;
      if (!scan_hit) begin
        st_r <= bfa_pkg::ST_NONE;
      end
    end
    if (state_r == bfa_pkg::S_MOD) begin
      if (!scan_op) begin
        prev_r <= rd_data[pos_r];
      end else if (fany) begin
        prev_r  <= rd_data[fpos];
        found_r <= found_c;
      end else begin
        st_r <= bfa_pkg::ST_NONE;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_load) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_status_r <= st_r;
      out_prev_r   <= prev_r;
      out_found_r  <= found_r;
    end
  end

  assign out_if.valid          = out_valid_r;
  assign out_if.status         = out_status_r;
  assign out_if.previous_value = out_prev_r;
  assign out_if.found_index    = out_found_r;

  bfa_flag_mem #(
    .WORD_COUNT (WORD_COUNT),
    .WORD_BITS  (WORD_BITS),
    .WA_W       (WA_W)
  ) u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (state_r == bfa_pkg::S_RD),
    .rd_addr (addr_r),
    .rd_data (rd_data),
    .upd     (upd),
    .wr_addr (addr_r),
    .wr_data (wr_data)
  );

  bfa_scan #(
    .WORD_COUNT (WORD_COUNT),
    .WORD_BITS  (WORD_BITS),
    .WA_W       (WA_W),
    .ACT_W      (ACT_W)
  ) u_scan (
    .clk      (clk),
    .rst_n    (rst_n),
    .upd      (upd),
    .upd_addr (addr_r),
    .start    (scan_start),
    .claim    (in_op == bfa_pkg::OP_CLAIM),
    .active_n (active_n),
    .hit      (scan_hit),
    .word     (scan_word)
  );

  // an accepted word always moves the controller out of idle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> state_r != bfa_pkg::S_IDLE)
    else $error("controller idle after accepting a request");

  // a claimed or released bit lies below the active count
  a_found_active: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == bfa_pkg::S_MOD && scan_op && fany) |-> CW'(found_c) < CW'(active_n))
    else $error("search picked a bit outside the active range");

  // range errors come only from single-bit requests
  a_range_single: assert property (@(posedge clk) disable iff (!rst_n)
    (res_load && st_r == bfa_pkg::ST_RANGE) |->
      (op_r == bfa_pkg::OP_TEST || op_r == bfa_pkg::OP_SET || op_r == bfa_pkg::OP_CLEAR))
    else $error("range status on a non single-bit request");

  // found index is zero for anything but a search
  a_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (res_load && !scan_op) |-> found_r == '0)
    else $error("found index set on a non search request");

endmodule

/* rtl/bfa_flag_mem.sv */
// ----------------------------------------------------------------------------
// bfa_flag_mem - flag word store
// Single-port synchronous RAM with a registered read; per-word valid bits and
// a fill value give reset and bulk clear/set without a clearing pass.
// ----------------------------------------------------------------------------
module bfa_flag_mem #(
  parameter int WORD_COUNT = 128,
  parameter int WORD_BITS  = 32,
  parameter int WA_W       = 7
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  rd_en,
  input  logic [WA_W-1:0]       rd_addr,
  output logic [WORD_BITS-1:0]  rd_data,
  input  bfa_pkg::flag_upd_t    upd,
  input  logic [WA_W-1:0]       wr_addr,
  input  logic [WORD_BITS-1:0]  wr_data
);

  logic [WORD_BITS-1:0]  mem [WORD_COUNT];
  logic [WORD_BITS-1:0]  rd_word_r;
  logic                  rd_valid_r;
  logic [WORD_COUNT-1:0] valid_r;
  logic                  fill_r;

  always_ff @(posedge clk) begin
    if (upd.wr) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_word_r  <= mem[rd_addr];
      rd_valid_r <= valid_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      fill_r  <= 1'b0;
    end else if (upd.bulk) begin
      valid_r <= '0;
      fill_r  <= upd.bulk_val;
    end else if (upd.wr) begin
      valid_r[wr_addr] <= 1'b1;
    end
  end

  // a word never written since reset or the last bulk operation reads as the fill value
  assign rd_data = rd_valid_r ? rd_word_r : {WORD_BITS{fill_r}};

endmodule

/* rtl/bfa_scan.sv */
// ----------------------------------------------------------------------------
// bfa_scan - word summaries and first-candidate search
// Keeps full/empty flags per word and finds the lowest active word that may
// hold a wanted bit, through a registered two-level search.
// ----------------------------------------------------------------------------
module bfa_scan #(
  parameter int WORD_COUNT = 128,
  parameter int WORD_BITS  = 32,
  parameter int WA_W       = 7,
  parameter int ACT_W      = 13
) (
  input  logic                clk,
  input  logic                rst_n,
  input  bfa_pkg::flag_upd_t  upd,
  input  logic [WA_W-1:0]     upd_addr,
  input  logic                start,
  input  logic                claim,
  input  logic [ACT_W-1:0]    active_n,
  output logic                hit,
  output logic [WA_W-1:0]     word
);

  localparam int SG        = bfa_pkg::SCAN_GROUP;
  localparam int GRP_COUNT = (WORD_COUNT + SG - 1) / SG;
  localparam int LOC_W     = $clog2(SG);
  localparam int GRP_W     = (GRP_COUNT > 1) ? $clog2(GRP_COUNT) : 1;
  localparam int PAD       = GRP_COUNT * SG;

  logic [WORD_COUNT-1:0] full_r;
  logic [WORD_COUNT-1:0] empty_r;
  logic [PAD-1:0]        cand;
  logic [GRP_COUNT-1:0]  grp_hit_c;
  logic [LOC_W-1:0]      grp_loc_c [GRP_COUNT];
  logic [GRP_COUNT-1:0]  grp_hit_r;
  logic [LOC_W-1:0]      grp_loc_r [GRP_COUNT];
  logic [GRP_W-1:0]      sel;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_r  <= '0;
      empty_r <= '1;
    end else if (upd.bulk) begin
      full_r  <= {WORD_COUNT{upd.bulk_val}};
      empty_r <= {WORD_COUNT{!upd.bulk_val}};
    end else if (upd.wr) begin
      full_r[upd_addr]  <= upd.word_full;
      empty_r[upd_addr] <= upd.word_empty;
    end
  end

  // only the boundary word can be a false candidate, and it is the last one
  always_comb begin
    cand = '0;
    for (int w = 0; w < WORD_COUNT; w++) begin
      cand[w] = (active_n > ACT_W'(w * WORD_BITS)) && (claim ? !full_r[w] : !empty_r[w]);
    end
  end

  always_comb begin
    for (int g = 0; g < GRP_COUNT; g++) begin
      grp_hit_c[g] = |cand[g*SG +: SG];
      grp_loc_c[g] = '0;
      for (int i = SG - 1; i >= 0; i--) begin
        if (cand[g*SG + i]) begin
          grp_loc_c[g] = LOC_W'(i);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      grp_hit_r <= grp_hit_c;
      for (int g = 0; g < GRP_COUNT; g++) begin
        grp_loc_r[g] <= grp_loc_c[g];
      end
    end
  end

  always_comb begin
    hit = 1'b0;
    sel = '0;
    for (int g = GRP_COUNT - 1; g >= 0; g--) begin
      if (grp_hit_r[g]) begin
        hit = 1'b1;
        sel = GRP_W'(g);
      end
    end
    word = WA_W'({sel, grp_loc_r[sel]});
  end

endmodule

/* verif/tb.sv */
// ----------------------------------------------------------------------------
// tb - bitmap first-free allocator testbench
// Drives test, set, clear, claim, release and bulk requests under random
// idling on both channels, across several bit counts, and checks every result
// word against a shadow bitmap kept in the bench.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NBITS = bfa_pkg::MAX_BITS_DEF;

  typedef struct packed {
    bfa_pkg::op_t                op;
    logic [bfa_pkg::IDX_W-1:0]   idx;
  } alloc_req_t;

  typedef struct packed {
    bfa_pkg::status_t            status;
    logic                        prev;
    logic [bfa_pkg::IDX_W-1:0]   found;
  } alloc_reply_t;

  logic                      clk   = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      cfg_we;
  logic [bfa_pkg::CFG_W-1:0] cfg_wdata;

  bfa_in_if  req_ch();
  bfa_out_if rsp_ch();

  bitmap_first_free_allocator u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_if     (req_ch),
    .out_if    (rsp_ch)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // shadow of the flag store and the bit count register
  logic [NBITS-1:0]          shadow_flags       = '0;
  logic [bfa_pkg::CFG_W-1:0] shadow_bits_in_use = bfa_pkg::CFG_RESET;

  alloc_req_t   req_backlog[$];
  alloc_reply_t awaited_replies[$];
  int unsigned  fault_count = 0;

  function automatic int unsigned visible_bits(logic [bfa_pkg::CFG_W-1:0] v);
    return (v > NBITS) ? NBITS : int'(v);
  endfunction

  function automatic alloc_reply_t apply_request(alloc_req_t rq);
    alloc_reply_t rs;
    int unsigned  span;
    int           b;
    logic         want;
    logic         hit;
    span = visible_bits(shadow_bits_in_use);
    rs   = '{bfa_pkg::ST_OK, 1'b0, '0};
    case (rq.op)
      bfa_pkg::OP_TEST, bfa_pkg::OP_SET, bfa_pkg::OP_CLEAR: begin
        if (rq.idx >= span) begin
          rs.status = bfa_pkg::ST_RANGE;
        end else begin
          rs.prev = shadow_flags[rq.idx];
          if (rq.op == bfa_pkg::OP_SET) shadow_flags[rq.idx] = 1'b1;
          else if (rq.op == bfa_pkg::OP_CLEAR) shadow_flags[rq.idx] = 1'b0;
        end
      end
      bfa_pkg::OP_CLAIM, bfa_pkg::OP_RELEASE: begin
        // claim looks for a clear bit, release for a set one
        want      = (rq.op == bfa_pkg::OP_RELEASE);
        hit       = 1'b0;
        rs.status = bfa_pkg::ST_NONE;
        for (b = 0; b < span && !hit; b++) begin
          if (shadow_flags[b] == want) begin
            hit             = 1'b1;
            shadow_flags[b] = !want;
            rs.status       = bfa_pkg::ST_OK;
            rs.prev         = want;
            rs.found        = b[bfa_pkg::IDX_W-1:0];
          end
        end
      end
      bfa_pkg::OP_CLEAR_ALL: shadow_flags = '0;
      bfa_pkg::OP_SET_ALL:   shadow_flags = '1;
      default:               ;
    endcase
    return rs;
  endfunction

  // random stretches during which neither side idles
  bit          brisk       = 1'b0;
  int unsigned brisk_timer = 0;

  always @(negedge clk) begin
    if (brisk_timer == 0) begin
      brisk       = ($urandom_range(0, 3) == 0);
      brisk_timer = $urandom_range(20, 120);
    end else begin
      brisk_timer = brisk_timer - 1;
    end
  end

  function automatic int unsigned pick_idle();
    return brisk ? 0 : $urandom_range(0, 7);
  endfunction

  // request driver
  int unsigned send_gap = 0;

  always @(posedge clk) begin
    alloc_req_t nxt;
    if (!rst_n) begin
      req_ch.valid <= 1'b0;
      send_gap = 0;
    end else if (!req_ch.valid || req_ch.ready) begin
      if (send_gap != 0) begin
        req_ch.valid <= 1'b0;
        send_gap = send_gap - 1;
      end else if (req_backlog.size() != 0) begin
        nxt = req_backlog.pop_front();
        req_ch.valid     <= 1'b1;
        req_ch.operation <= nxt.op;
        req_ch.bit_index <= nxt.idx;
        send_gap = pick_idle();
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  // result monitor and prediction; result checked before a new word is predicted
  int unsigned take_stall = 0;

  always @(posedge clk) begin
    alloc_reply_t want;
    alloc_req_t   got_req;
    if (!rst_n) begin
      rsp_ch.ready <= 1'b0;
      take_stall = 0;
    end else begin
      if (cfg_we) shadow_bits_in_use = cfg_wdata;
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (awaited_replies.size() == 0) begin
          if (fault_count < 10)
            $display("%t: result word with none awaited: status %0d prev %0d found %0d",
                     $realtime, rsp_ch.status, rsp_ch.previous_value, rsp_ch.found_index);
          fault_count++;
        end else begin
          want = awaited_replies.pop_front();
          if (rsp_ch.status !== want.status || rsp_ch.previous_value !== want.prev ||
              rsp_ch.found_index !== want.found) begin
            if (fault_count < 10)
              $display("%t: expected status %0d prev %0d found %0d, got %0d %0d %0d",
                       $realtime, want.status, want.prev, want.found,
                       rsp_ch.status, rsp_ch.previous_value, rsp_ch.found_index);
            fault_count++;
          end
        end
        take_stall = pick_idle();
      end else if (take_stall != 0) begin
        take_stall = take_stall - 1;
      end
      rsp_ch.ready <= (take_stall == 0);
      if (req_ch.valid && req_ch.ready) begin
        got_req = '{bfa_pkg::op_t'(req_ch.operation), req_ch.bit_index};
        awaited_replies.push_back(apply_request(got_req));
      end
    end
  end

  task automatic queue_req(bfa_pkg::op_t op, int unsigned idx);
    alloc_req_t rq;
    rq.op  = op;
    rq.idx = idx[bfa_pkg::IDX_W-1:0];
    req_backlog.push_back(rq);
  endtask

  // wait for the sender to run dry and every result word to come back
  task automatic settle();
    do @(negedge clk);
    while (req_backlog.size() != 0 || req_ch.valid || awaited_replies.size() != 0);
  endtask

  task automatic write_bits_in_use(logic [bfa_pkg::CFG_W-1:0] v);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(negedge clk);
  endtask

  function automatic int unsigned rand_index(int unsigned span);
    int unsigned r;
    int          v;
    r = $urandom_range(0, 9);
    if (r < 6 && span > 0) return $urandom_range(0, span - 1);
    if (r < 8) begin
      // around the top of the active range
      v = int'(span) - 2 + int'($urandom_range(0, 3));
      if (v < 0) v = 0;
      if (v > NBITS - 1) v = NBITS - 1;
      return v;
    end
    return $urandom_range(0, NBITS - 1);
  endfunction

  task automatic queue_random(int unsigned span, int unsigned count);
    int unsigned  made;
    int unsigned  k;
    int unsigned  pick;
    bfa_pkg::op_t op;
    bfa_pkg::op_t fill_op;
    bfa_pkg::op_t poke_op;
    bfa_pkg::op_t scan_op;
    made = 0;
    while (made < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
        // fill or empty the map, punch holes, then scan them back out
        if (pick < 5) begin
          fill_op = bfa_pkg::OP_SET_ALL;
          poke_op = bfa_pkg::OP_CLEAR;
          scan_op = bfa_pkg::OP_CLAIM;
        end else begin
          fill_op = bfa_pkg::OP_CLEAR_ALL;
          poke_op = bfa_pkg::OP_SET;
          scan_op = bfa_pkg::OP_RELEASE;
        end
        k = $urandom_range(1, 6);
        queue_req(fill_op, rand_index(span));
        repeat (k) queue_req(poke_op, rand_index(span));
        repeat (k + 1) queue_req(scan_op, rand_index(span));
        made += 2 * k + 2;
      end else begin
        if (pick < 25)      op = bfa_pkg::OP_TEST;
        else if (pick < 40) op = bfa_pkg::OP_SET;
        else if (pick < 54) op = bfa_pkg::OP_CLEAR;
        else if (pick < 73) op = bfa_pkg::OP_CLAIM;
        else if (pick < 91) op = bfa_pkg::OP_RELEASE;
        else if (pick < 95) op = bfa_pkg::OP_CLEAR_ALL;
        else if (pick < 98) op = bfa_pkg::OP_SET_ALL;
        else                op = bfa_pkg::OP_NOP;
        queue_req(op, rand_index(span));
        made++;
      end
    end
  endtask

  initial begin
    logic [bfa_pkg::CFG_W-1:0] span_plan [9];
    int unsigned               span;
    int unsigned               top;
    cfg_we           = 1'b0;
    cfg_wdata        = '0;
    req_ch.valid     = 1'b0;
    req_ch.operation = bfa_pkg::OP_NOP;
    req_ch.bit_index = '0;
    rsp_ch.ready     = 1'b0;
    span_plan = '{13'd37, 13'd1, 13'd0, 13'd8191, 13'd4097, 13'd300, 13'd4096, 13'd33,
                  13'd1024};

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // full map at the reset bit count
    queue_req(bfa_pkg::OP_TEST, 0);
    queue_req(bfa_pkg::OP_TEST, NBITS - 1);
    queue_req(bfa_pkg::OP_SET, NBITS - 1);
    queue_req(bfa_pkg::OP_SET, NBITS - 1);
    queue_req(bfa_pkg::OP_TEST, NBITS - 1);
    queue_req(bfa_pkg::OP_CLEAR, NBITS - 1);
    queue_req(bfa_pkg::OP_CLAIM, 0);
    queue_req(bfa_pkg::OP_CLAIM, NBITS - 1);
    queue_req(bfa_pkg::OP_RELEASE, 0);
    queue_req(bfa_pkg::OP_SET_ALL, 0);
    queue_req(bfa_pkg::OP_CLAIM, 0);
    queue_req(bfa_pkg::OP_TEST, 12'hAAA);
    queue_req(bfa_pkg::OP_TEST, 12'h555);
    queue_req(bfa_pkg::OP_RELEASE, 0);
    queue_req(bfa_pkg::OP_CLEAR, 1);
    queue_req(bfa_pkg::OP_CLAIM, 0);
    queue_req(bfa_pkg::OP_CLEAR_ALL, 0);
    queue_req(bfa_pkg::OP_RELEASE, 0);
    queue_req(bfa_pkg::OP_NOP, NBITS - 1);
    queue_req(bfa_pkg::OP_NOP, 0);

    // sender holds off between phases until all result words are back
    foreach (span_plan[p]) begin
      settle();
      write_bits_in_use(span_plan[p]);
      span = visible_bits(span_plan[p]);
      top  = (span == 0) ? 0 : span - 1;
      queue_req(bfa_pkg::OP_SET_ALL, 0);
      queue_req(bfa_pkg::OP_CLAIM, 0);
      queue_req(bfa_pkg::OP_CLEAR, top);
      queue_req(bfa_pkg::OP_CLAIM, 0);
      queue_req(bfa_pkg::OP_TEST, (span < NBITS) ? span : NBITS - 1);
      queue_req(bfa_pkg::OP_CLEAR_ALL, 0);
      queue_req(bfa_pkg::OP_RELEASE, 0);
      queue_random(span, 45);
    end

    settle();
    repeat (16) @(negedge clk);
    if (fault_count == 0 && awaited_replies.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

/* filelist.f */
rtl/bfa_pkg.sv
rtl/bfa_if.sv
rtl/bfa_flag_mem.sv
rtl/bfa_scan.sv
rtl/bitmap_first_free_allocator.sv
verif/tb.sv
